>>> hw/rtl/hpw_pkg.sv
// Shared types and constants for the parent-walk Huffman encoder.
`timescale 1ns / 1ps
`default_nettype none

package hpw_pkg;

  localparam int BYTE_W = 8;
  localparam int PTR_W  = 9;
  localparam int SYM_W  = 8;
  localparam int ENTRY_W = PTR_W + 2;

  localparam logic [2:0] CNT_FULL = 3'(BYTE_W - 1);

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PTR_W-1:0] node_index;
    logic [PTR_W-1:0] node_parent;
    logic             node_has_parent;
    logic             node_branch;
    logic [SYM_W-1:0] symbol;
  } hpw_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } hpw_out_t;

  typedef struct packed {
    logic             branch;
    logic             has_parent;
    logic [PTR_W-1:0] parent;
  } node_entry_t;

  typedef struct packed {
    logic push;
    logic bit_val;
    logic last;
  } pk_cmd_t;

  typedef struct packed {
    logic ready;
    logic empty;
  } pk_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP_START,
    ST_POP,
    ST_FLUSH
  } hpw_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/hpw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/hpw_pack.sv
// Bit-serial byte packer with the registered output beat.
`timescale 1ns / 1ps
`default_nettype none

module hpw_pack (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hpw_pkg::pk_cmd_t cmd,
  output hpw_pkg::pk_stat_t     stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hpw_pkg::hpw_out_t     out_data
);

  logic [hpw_pkg::BYTE_W-1:0] buf_r, buf_nxt, shifted;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  hpw_pkg::hpw_out_t          out_data_r, out_data_nxt;

  assign stat.ready = (cnt_r != hpw_pkg::CNT_FULL) || !out_valid_r || out_ready;
  assign stat.empty = (cnt_r == 3'd0);
  assign shifted    = {buf_r[hpw_pkg::BYTE_W-2:0], cmd.bit_val};

  always_comb begin
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.push && stat.ready) begin
      if (cnt_r == hpw_pkg::CNT_FULL) begin
        out_data_nxt.out_byte = shifted;
        out_data_nxt.last     = cmd.last;
        out_valid_nxt         = 1'b1;
        buf_nxt               = '0;
        cnt_nxt               = 3'd0;
      end else begin
        buf_nxt = shifted;
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/hpw_ctrl.sv
// Sequencer for table writes, the leaf-to-root walk, the code pop and the flush.
`timescale 1ns / 1ps
`default_nettype none

module hpw_ctrl #(
  parameter int NODES = 512,
  parameter int MAX_CODE_BITS = 256,
  localparam int NAW = $clog2(NODES),
  localparam int SAW = $clog2(MAX_CODE_BITS),
  localparam int DW  = $clog2(MAX_CODE_BITS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire hpw_pkg::hpw_in_t               in_data,
  output logic                                n_we,
  output logic [NAW-1:0]                      n_waddr,
  output logic [hpw_pkg::ENTRY_W-1:0]         n_wdata,
  output logic [NAW-1:0]                      n_raddr,
  input  wire logic [hpw_pkg::ENTRY_W-1:0]    n_rdata,
  output logic                                s_we,
  output logic [SAW-1:0]                      s_waddr,
  output logic                                s_wdata,
  output logic [SAW-1:0]                      s_raddr,
  input  wire logic                           s_rdata,
  output hpw_pkg::pk_cmd_t                    pk_cmd,
  input  wire hpw_pkg::pk_stat_t              pk_stat
);

  hpw_pkg::hpw_state_t  state_r, state_nxt;
  logic [DW-1:0]        depth_r, depth_nxt, depth_inc, walk_depth;
  logic [SAW-1:0]       pos_r, pos_nxt;
  hpw_pkg::node_entry_t entry, wr_entry;
  logic                 in_fire, sym_ok, idx_ok, parent_ok, room_ok, pop_fire;

  assign entry      = hpw_pkg::node_entry_t'(n_rdata);
  assign in_fire    = in_valid && in_ready;
  assign sym_ok     = 32'(in_data.symbol) < NODES;
  assign idx_ok     = 32'(in_data.node_index) < NODES;
  assign parent_ok  = 32'(entry.parent) < NODES;
  assign depth_inc  = depth_r + 1'b1;
  assign room_ok    = 32'(depth_inc) < MAX_CODE_BITS;
  assign walk_depth = entry.has_parent ? depth_inc : depth_r;
  assign pop_fire   = (state_r == hpw_pkg::ST_POP) && pk_stat.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpw_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            hpw_pkg::OP_ENCODE: begin
              if (sym_ok) begin
                state_nxt = hpw_pkg::ST_WALK;
              end
            end
            hpw_pkg::OP_FLUSH: state_nxt = hpw_pkg::ST_FLUSH;
            default:           state_nxt = hpw_pkg::ST_IDLE;
          endcase
        end
      end
      hpw_pkg::ST_WALK: begin
        if (!entry.has_parent) begin
          state_nxt = (depth_r != '0) ? hpw_pkg::ST_POP_START : hpw_pkg::ST_IDLE;
        end else if (!(parent_ok && room_ok)) begin
          state_nxt = hpw_pkg::ST_POP_START;
        end
      end
      hpw_pkg::ST_POP_START: state_nxt = hpw_pkg::ST_POP;
      hpw_pkg::ST_POP: begin
        if (pk_stat.ready && (pos_r == '0)) begin
          state_nxt = hpw_pkg::ST_IDLE;
        end
      end
      hpw_pkg::ST_FLUSH: begin
        if (pk_stat.empty) begin
          state_nxt = hpw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hpw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    depth_nxt = depth_r;
    pos_nxt   = pos_r;
    case (state_r)
      hpw_pkg::ST_IDLE: depth_nxt = '0;
      hpw_pkg::ST_WALK: begin
        depth_nxt = walk_depth;
        pos_nxt   = SAW'(walk_depth - 1'b1);
      end
      hpw_pkg::ST_POP: begin
        if (pop_fire && (pos_r != '0)) begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      default: begin
        depth_nxt = depth_r;
        pos_nxt   = pos_r;
      end
    endcase
  end

  always_comb begin
    wr_entry.branch     = in_data.node_branch;
    wr_entry.has_parent = in_data.node_has_parent;
    wr_entry.parent     = in_data.node_parent;

    in_ready = (state_r == hpw_pkg::ST_IDLE);
    n_we     = in_fire && (in_data.opcode == hpw_pkg::OP_WRITE) && idx_ok;
    n_waddr  = NAW'(in_data.node_index);
    n_wdata  = wr_entry;
    n_raddr  = (state_r == hpw_pkg::ST_WALK) ? NAW'(entry.parent) : NAW'(in_data.symbol);

    s_we    = (state_r == hpw_pkg::ST_WALK) && entry.has_parent;
    s_waddr = depth_r[SAW-1:0];
    s_wdata = entry.branch;
    s_raddr = (pop_fire && (pos_r != '0)) ? pos_r - 1'b1 : pos_r;

    case (state_r)
      hpw_pkg::ST_POP: begin
        pk_cmd.push    = 1'b1;
        pk_cmd.bit_val = s_rdata;
        pk_cmd.last    = 32'(pos_r) < 32'(hpw_pkg::BYTE_W);
      end
      hpw_pkg::ST_FLUSH: begin
        pk_cmd.push    = !pk_stat.empty;
        pk_cmd.bit_val = 1'b0;
        pk_cmd.last    = 1'b1;
      end
      default: begin
        pk_cmd.push    = 1'b0;
        pk_cmd.bit_val = 1'b0;
        pk_cmd.last    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpw_pkg::ST_IDLE;
      depth_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/huffman_parent_walk_encoder.sv
// Top level of the parent-walk Huffman encoder: sequencer, node table, code stack, packer.
// A write beat completes on acceptance. An encode beat with an L-bit code (L of one or more)
// runs the accept cycle, one node-table read per walk step up to the root, a state priming
// the code-stack read and L pops of one bit each; a root leaf ends after its walk step. A flush
// beat pushes zero bits, one per cycle while the packer is ready, until the buffer is empty.
// Synchronous reset clears the sequencer, bit buffer, bit count and output valid only.
`timescale 1ns / 1ps
`default_nettype none

module huffman_parent_walk_encoder #(
  parameter int NODES = 512,
  parameter int MAX_CODE_BITS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hpw_pkg::hpw_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hpw_pkg::hpw_out_t      out_data
);

  localparam int NAW = $clog2(NODES);
  localparam int SAW = $clog2(MAX_CODE_BITS);

  logic                        n_we, s_we, s_wdata, s_rdata;
  logic [NAW-1:0]              n_waddr, n_raddr;
  logic [hpw_pkg::ENTRY_W-1:0] n_wdata, n_rdata;
  logic [SAW-1:0]              s_waddr, s_raddr;
  hpw_pkg::pk_cmd_t            pk_cmd;
  hpw_pkg::pk_stat_t           pk_stat;

  hpw_ctrl #(
    .NODES         (NODES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .n_we     (n_we),
    .n_waddr  (n_waddr),
    .n_wdata  (n_wdata),
    .n_raddr  (n_raddr),
    .n_rdata  (n_rdata),
    .s_we     (s_we),
    .s_waddr  (s_waddr),
    .s_wdata  (s_wdata),
    .s_raddr  (s_raddr),
    .s_rdata  (s_rdata),
    .pk_cmd   (pk_cmd),
    .pk_stat  (pk_stat)
  );

  hpw_ram #(
    .WIDTH (hpw_pkg::ENTRY_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  hpw_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CODE_BITS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  hpw_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pk_cmd),
    .stat      (pk_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hpw_checker.sv
// Port-level assertions for the parent-walk Huffman encoder and their bind.
`timescale 1ns / 1ps
`default_nettype none

module hpw_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire hpw_pkg::hpw_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire hpw_pkg::hpw_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output beat changed or dropped while stalled.");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Block not idle and empty after reset.");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == hpw_pkg::OP_WRITE) && !out_valid
    |=> !out_valid && in_ready)
    else $error("Table write produced a beat or blocked the input.");

  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == hpw_pkg::OP_FLUSH) |=> !in_ready)
    else $error("Input accepted during a flush.");

endmodule

bind huffman_parent_walk_encoder hpw_checker u_hpw_checker (.*);

`default_nettype wire

>>> tb/sv/huffman_parent_walk_encoder_tb.sv
// Self-checking testbench for the parent-walk Huffman encoder.
`timescale 1ns / 1ps

module huffman_parent_walk_encoder_tb;

  localparam int TB_NODES = 512;
  localparam int TB_CODE_MAX = 256;
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int IN_W = $bits(hpw_pkg::hpw_in_t);
  localparam int RANDOM_ITEMS = 205;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES = 400;

  class codeword_packer;
    hpw_pkg::node_entry_t node_tab [TB_NODES];
    bit                   written [TB_NODES];
    logic [7:0]           pack_byte;
    int unsigned          pack_bits;
    hpw_pkg::hpw_out_t    code_bytes [$];
    int unsigned          errors;
    int unsigned          bytes_seen;
    int unsigned          longest_code;

    function new();
      pack_byte = '0;
      pack_bits = 0;
      errors = 0;
      bytes_seen = 0;
      longest_code = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function bit walk_is_safe(logic [hpw_pkg::SYM_W-1:0] sym);
      int unsigned cur;
      int unsigned steps;
      cur = 32'(sym);
      for (steps = 0; steps < TB_CODE_MAX; steps++) begin
        if (!written[cur]) return 1'b0;
        if (!node_tab[cur].has_parent) return 1'b1;
        cur = 32'(node_tab[cur].parent);
      end
      return 1'b1;
    endfunction

    function void note_input(hpw_pkg::hpw_in_t beat);
      bit                code [TB_CODE_MAX];
      int unsigned       depth;
      int unsigned       cur;
      hpw_pkg::hpw_out_t burst [$];
      hpw_pkg::hpw_out_t ob;
      case (beat.opcode)
        hpw_pkg::OP_WRITE: begin
          node_tab[beat.node_index].parent = beat.node_parent;
          node_tab[beat.node_index].has_parent = beat.node_has_parent;
          node_tab[beat.node_index].branch = beat.node_branch;
          written[beat.node_index] = 1'b1;
        end
        hpw_pkg::OP_ENCODE: begin
          depth = 0;
          cur = 32'(beat.symbol);
          while (depth < TB_CODE_MAX && node_tab[cur].has_parent === 1'b1) begin
            code[depth] = node_tab[cur].branch;
            depth++;
            cur = 32'(node_tab[cur].parent);
          end
          if (depth > longest_code) longest_code = depth;
          while (depth > 0) begin
            depth--;
            pack_byte = {pack_byte[6:0], code[depth]};
            pack_bits++;
            if (pack_bits == 8) begin
              ob.out_byte = pack_byte;
              ob.last = 1'b0;
              burst.insert(burst.size(), ob);
              pack_byte = '0;
              pack_bits = 0;
            end
          end
        end
        hpw_pkg::OP_FLUSH: begin
          if (pack_bits != 0) begin
            ob.out_byte = 8'(pack_byte << (8 - pack_bits));
            ob.last = 1'b0;
            burst.insert(burst.size(), ob);
            pack_byte = '0;
            pack_bits = 0;
          end
        end
        default: ;
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) code_bytes.insert(code_bytes.size(), burst[i]);
    endfunction

    function void check_result(hpw_pkg::hpw_out_t got);
      hpw_pkg::hpw_out_t want;
      if (code_bytes.size() == 0) begin
        $display("%0t: unexpected output beat: expected none, got byte %02h last %0b",
                 $time, got.out_byte, got.last);
        errors++;
        return;
      end
      want = code_bytes[0];
      code_bytes.delete(0);
      bytes_seen++;
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return code_bytes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  hpw_pkg::hpw_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  hpw_pkg::hpw_out_t out_data;

  codeword_packer packer;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  bit             hold_req = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    next_inner = 0;
  int unsigned    cycle_cnt = 0;
  logic [7:0]     tree_leaves [$];

  huffman_parent_walk_encoder #(
    .NODES(TB_NODES),
    .MAX_CODE_BITS(TB_CODE_MAX)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("huffman_parent_walk_encoder regression: fail");
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) packer.check_result(out_data);
  end

  function automatic hpw_pkg::hpw_in_t write_beat(logic [hpw_pkg::PTR_W-1:0] idx,
                                                  logic [hpw_pkg::PTR_W-1:0] par,
                                                  logic hp, logic br);
    hpw_pkg::hpw_in_t b;
    b = IN_W'($urandom);
    b.opcode = hpw_pkg::OP_WRITE;
    b.node_index = idx;
    b.node_parent = par;
    b.node_has_parent = hp;
    b.node_branch = br;
    return b;
  endfunction

  function automatic hpw_pkg::hpw_in_t encode_beat(logic [hpw_pkg::SYM_W-1:0] sym);
    hpw_pkg::hpw_in_t b;
    b = IN_W'($urandom);
    b.opcode = hpw_pkg::OP_ENCODE;
    b.symbol = sym;
    return b;
  endfunction

  function automatic hpw_pkg::hpw_in_t flush_beat();
    hpw_pkg::hpw_in_t b;
    b = IN_W'($urandom);
    b.opcode = hpw_pkg::OP_FLUSH;
    return b;
  endfunction

  function automatic hpw_pkg::hpw_in_t idle_beat();
    hpw_pkg::hpw_in_t b;
    b = IN_W'($urandom);
    b.opcode = OP_IDLE;
    return b;
  endfunction

  task automatic send_beat(hpw_pkg::hpw_in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    packer.note_input(beat);
    if (beat.opcode != OP_IDLE) items_sent++;
  endtask

  task automatic build_tree(int unsigned n_leaves, bit chain);
    bit          picked [256];
    int unsigned pool [$];
    int unsigned a;
    int unsigned b;
    int unsigned pick_at;
    int unsigned inner;
    int unsigned sym;
    logic        br;
    tree_leaves.delete();
    while (tree_leaves.size() < n_leaves) begin
      sym = $urandom_range(0, 255);
      if (!picked[sym]) begin
        picked[sym] = 1'b1;
        tree_leaves.insert(tree_leaves.size(), 8'(sym));
        pool.insert(pool.size(), sym);
      end
    end
    while (pool.size() > 1) begin
      if (chain) begin
        a = pool[pool.size() - 1];
        pool.delete(pool.size() - 1);
        b = pool[0];
        pool.delete(0);
      end else begin
        pick_at = $urandom_range(0, pool.size() - 1);
        a = pool[pick_at];
        pool.delete(pick_at);
        pick_at = $urandom_range(0, pool.size() - 1);
        b = pool[pick_at];
        pool.delete(pick_at);
      end
      inner = 256 + next_inner;
      next_inner = (next_inner + 1) % 256;
      br = 1'($urandom_range(0, 1));
      send_beat(write_beat(9'(a), 9'(inner), 1'b1, br));
      send_beat(write_beat(9'(b), 9'(inner), 1'b1, ~br));
      pool.insert(pool.size(), inner);
    end
    send_beat(write_beat(9'(pool[0]), 9'($urandom_range(0, 511)), 1'b0,
                         1'($urandom_range(0, 1))));
  endtask

  initial begin : stimulus
    int unsigned round;
    int unsigned directed_items;
    int unsigned ops;
    int unsigned roll;
    int unsigned n_leaves;
    logic [7:0]  sym;
    bit          chain;

    packer = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(flush_beat());
    send_beat(idle_beat());
    send_beat(write_beat(9'd65, 9'd511, 1'b0, 1'b1));
    send_beat(encode_beat(8'd65));
    send_beat(write_beat(9'd0, 9'd511, 1'b1, 1'b0));
    send_beat(write_beat(9'd255, 9'd511, 1'b1, 1'b1));
    send_beat(write_beat(9'd511, 9'd0, 1'b0, 1'b0));
    send_beat(encode_beat(8'd0));
    send_beat(encode_beat(8'd255));
    send_beat(flush_beat());
    send_beat(write_beat(9'd9, 9'd10, 1'b1, 1'b1));
    send_beat(write_beat(9'd10, 9'd9, 1'b1, 1'b0));
    send_beat(encode_beat(8'd9));
    send_beat(encode_beat(8'd255));
    send_beat(encode_beat(8'd0));
    send_beat(encode_beat(8'd255));
    send_beat(encode_beat(8'd9));
    send_beat(flush_beat());
    directed_items = items_sent;

    round = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      case (round % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      if (round == 0) hold_req = 1'b1;
      chain = (round == 0) || ($urandom_range(0, 3) == 0);
      if (round == 0) n_leaves = 16;
      else n_leaves = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 16);
      build_tree(n_leaves, chain);
      ops = $urandom_range(10, 20);
      while (ops > 0 && items_sent < directed_items + RANDOM_ITEMS) begin
        ops--;
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
          sym = tree_leaves[$urandom_range(0, tree_leaves.size() - 1)];
          if (packer.walk_is_safe(sym)) send_beat(encode_beat(sym));
          else send_beat(flush_beat());
        end else if (roll < 80) begin
          send_beat(flush_beat());
        end else if (roll < 88) begin
          sym = 8'($urandom_range(0, 255));
          if (packer.walk_is_safe(sym)) send_beat(encode_beat(sym));
          else send_beat(flush_beat());
        end else if (roll < 94) begin
          send_beat(idle_beat());
        end else begin
          send_beat(write_beat(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
      end
      round++;
    end
    in_valid <= 1'b0;

    while (packer.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats (%0d after the directed part) across %0d tree rounds.",
             items_sent, items_sent - directed_items, round);
    $display("Checked %0d code bytes; longest codeword was %0d bits.",
             packer.bytes_seen, packer.longest_code);
    if (packer.errors == 0) begin
      $display("huffman_parent_walk_encoder regression: pass");
    end else begin
      $display("huffman_parent_walk_encoder regression: fail");
    end
    $finish;
  end

endmodule
